// ----- src/smm_pkg.sv -----
// ============================================================================
// smm_pkg : shared types and constants for the square matrix multiplier
// Element widths, index widths, order limits and the sequencer state type.
// ============================================================================
`default_nettype none
package smm_pkg;
    localparam int ElemW      = 32;
    localparam int IdxW       = 3;
    localparam int OrdW       = 2;
    localparam int MaxOrderDefault = 8;
    localparam logic [OrdW-1:0] OrderLog2Reset = 2'd2;

    typedef logic signed [ElemW-1:0] t_elem;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_COMPUTE,
        ST_DRAIN
    } t_state;

    // control handed along the cell chain
    typedef struct packed {
        logic clear;   // start a new dot product
        logic mac;     // accumulate this cycle
    } t_cell_ctl;
endpackage
`default_nettype wire

// ----- src/smm_if.sv -----
// ============================================================================
// smm_if : valid/ready channel interfaces
// Input pair channel, result channel and configuration write channel.
// ============================================================================
`default_nettype none
interface smm_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  a_element;
    logic signed [31:0]  b_element;
    modport source (output valid, a_element, b_element, input ready);
    modport sink   (input valid, a_element, b_element, output ready);
endinterface

interface smm_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  product_element;
    logic [2:0]          row_index;
    logic [2:0]          column_index;
    logic                last_element;
    modport source (output valid, product_element, row_index, column_index,
                    last_element, input ready);
    modport sink   (input valid, product_element, row_index, column_index,
                    last_element, output ready);
endinterface

interface smm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] order_log2;
    modport source (output valid, order_log2, input ready);
    modport sink   (input valid, order_log2, output ready);
endinterface
`default_nettype wire

// ----- src/smm_ram.sv -----
// ============================================================================
// smm_ram : generic single-port-write, one-read RAM
// Registered read data.
// ============================================================================
`default_nettype none
module smm_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(Depth)-1:0]  i_waddr,
    input  wire [Width-1:0]          i_wdata,
    input  wire [$clog2(Depth)-1:0]  i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/smm_cell.sv -----
// ============================================================================
// smm_cell : one multiply-accumulate cell of the chain
// Multiplies its operands, registers the product, accumulates, and hands
// its control on to the next cell.
// ============================================================================
`default_nettype none
module smm_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  smm_pkg::t_cell_ctl   i_ctl,
    input  wire [31:0]           i_a,
    input  wire [31:0]           i_b,
    output smm_pkg::t_cell_ctl   o_ctl,
    output logic [31:0]          o_acc
);
    import smm_pkg::*;

    t_cell_ctl   r_ctl;
    logic [31:0] r_prod;
    logic [31:0] r_acc;
    logic [31:0] w_prod;

    // low half of the product is all that survives the wrap
    assign w_prod = i_a * i_b;

    // stage product and pass control along
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_prod <= w_prod;
    end

    // accumulate one term per cycle while mac is set
    always_ff @(posedge i_clk) begin
        if (r_ctl.mac) begin
            r_acc <= r_ctl.clear ? r_prod : r_acc + r_prod;
        end
    end

    assign o_ctl = r_ctl;
    assign o_acc = r_acc;
endmodule
`default_nettype wire

// ----- src/square_matrix_multiply.sv -----
// ============================================================================
// square_matrix_multiply : square matrix product over a chain of MAC cells
// Loads A and B pairwise, then computes one product row at a time: cell c
// builds C[r][c] while the fire control ripples along the chain of cells.
// ============================================================================
//  channel   dir  payload                                          handshake
//  s_in      in   a_element, b_element                              valid/ready
//  m_out     out  product_element, row_index, column_index, last    valid/ready
//  s_cfg     in   order_log2                                        valid/ready
//
//  Loading writes each accepted pair to the A and B stores. The pair that
//  completes the matrices starts the product and input is held off until
//  the last result leaves. Each product row feeds N*N B words (one B
//  element per cycle), passes the read, snapshot and cell pipeline, and
//  then emits its N results; each result stall holds the drain.
//  Reset is synchronous, active low; stores need no clearing.
`default_nettype none
module square_matrix_multiply #(
    parameter int MaxOrder = smm_pkg::MaxOrderDefault
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    smm_in_if.sink     s_in,
    smm_out_if.source  m_out,
    smm_cfg_if.sink    s_cfg
);
    import smm_pkg::*;

    localparam int Depth = MaxOrder * MaxOrder;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW    = $clog2(Depth + 1);
    localparam logic [OrdW-1:0] MaxLog =
        OrdW'((MaxOrder >= 8) ? 3 : (MaxOrder >= 4) ? 2 : (MaxOrder >= 2) ? 1 : 0);
    localparam int NC = 1 << MaxLog;  // cells in the chain
    localparam int TW = (NC > 1) ? $clog2(NC) : 1;

    t_state           r_state, n_state;
    logic [OrdW-1:0]  r_olog;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [IdxW-1:0]  r_row, n_row;
    logic [IdxW-1:0]  r_k, n_k;      // term index
    logic [IdxW-1:0]  r_c, n_c;      // column index during feed/drain
    logic [3:0]       r_tail, n_tail;
    logic             w_feed;

    logic [OrdW-1:0]  w_log;
    logic [CW-1:0]    w_total;
    logic [IdxW:0]    w_n;

    assign w_log   = (r_olog > MaxLog) ? MaxLog : r_olog;
    assign w_n     = (IdxW+1)'(1) << w_log;
    assign w_total = CW'(1) << (2 * w_log);

    // sequencer register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_olog  <= OrderLog2Reset;
            r_cnt   <= '0;
            r_row   <= '0;
            r_k     <= '0;
            r_c     <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_k     <= n_k;
            r_c     <= n_c;
            r_tail  <= n_tail;
            if (s_cfg.valid && s_cfg.ready) begin
                r_olog <= s_cfg.order_log2;
                r_cnt  <= '0;
            end
        end
    end

    assign s_cfg.ready = 1'b1;
    assign s_in.ready  = (r_state == ST_LOAD);

    // next state: load, feed each row k by c, drain row outputs
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_row   = r_row;
        n_k     = r_k;
        n_c     = r_c;
        n_tail  = r_tail;
        w_feed  = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (s_in.valid) begin
                    if (r_cnt + CW'(1) >= w_total) begin
                        n_cnt   = '0;
                        n_state = ST_COMPUTE;
                        n_row   = '0;
                        n_k     = '0;
                        n_c     = '0;
                        n_tail  = '0;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            ST_COMPUTE: begin
                if (r_tail == '0) begin
                    w_feed = 1'b1;
                    if ({1'b0, r_c} == w_n - 1'b1) begin
                        n_c = '0;
                        if ({1'b0, r_k} == w_n - 1'b1) begin
                            n_k    = '0;
                            n_tail = 4'd1;
                        end else begin
                            n_k = r_k + 1'b1;
                        end
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                end else if (r_tail == 4'd4) begin
                    n_tail  = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_tail = r_tail + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (m_out.ready) begin
                    if ({1'b0, r_c} == w_n - 1'b1) begin
                        n_c = '0;
                        if ({1'b0, r_row} == w_n - 1'b1) begin
                            n_state = ST_LOAD;
                        end else begin
                            n_row   = r_row + 1'b1;
                            n_state = ST_COMPUTE;
                        end
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // stores; load address is the counter
    logic [AW-1:0] w_waddr, w_araddr, w_braddr;
    logic [31:0]   w_a_rd, w_b_rd;
    logic          w_we;

    assign w_we     = s_in.valid && s_in.ready;
    assign w_waddr  = AW'(r_cnt);
    assign w_araddr = AW'(({{IdxW{1'b0}}, r_row} << w_log) + {{IdxW{1'b0}}, r_k});
    assign w_braddr = AW'(({{IdxW{1'b0}}, r_k} << w_log) + {{IdxW{1'b0}}, r_c});

    smm_ram #(.Width(ElemW), .Depth(Depth)) u_ram_a (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(s_in.a_element),
        .i_raddr(w_araddr), .o_rdata(w_a_rd));
    smm_ram #(.Width(ElemW), .Depth(Depth)) u_ram_b (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(s_in.b_element),
        .i_raddr(w_braddr), .o_rdata(w_b_rd));

    // B words of row k arrive in column order and shift down a tap line;
    // once the last column has reached tap 0, tap (n-1-c) holds column c
    logic [31:0] r_bsh [NC];
    logic        r_last_col;
    logic        r_first_k;
    logic        r_snap;
    logic        r_snap_clr;

    // track the last column and first term through read latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= 1'b0;
            r_first_k  <= 1'b0;
            r_snap     <= 1'b0;
            r_snap_clr <= 1'b0;
        end else begin
            r_last_col <= w_feed && ({1'b0, r_c} == w_n - 1'b1);
            r_first_k  <= w_feed && (r_k == '0);
            r_snap     <= r_last_col;
            r_snap_clr <= r_last_col && r_first_k;
        end
    end

    // shift B words down the line
    always_ff @(posedge i_clk) begin
        r_bsh[0] <= w_b_rd;
        for (int i = 1; i < NC; i++) begin
            r_bsh[i] <= r_bsh[i-1];
        end
    end

    // A element: captured on the first column of each k
    logic [31:0] r_a_k;
    logic        r_a_cap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_cap <= 1'b0;
        end else begin
            r_a_cap <= w_feed && (r_c == '0);
        end
        if (r_a_cap) begin
            r_a_k <= w_a_rd;
        end
    end

    // cells fire once per k, after the full B row sits in the line
    t_cell_ctl r_fire;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fire <= '0;
        end else begin
            r_fire.mac   <= r_snap;
            r_fire.clear <= r_snap_clr;
        end
    end

    t_cell_ctl   w_ctl [NC+1];
    logic [31:0] w_acc [NC];
    logic [31:0] r_bcap [NC];
    logic [31:0] r_acap;

    // snapshot row of B and A at fire time
    always_ff @(posedge i_clk) begin
        if (r_snap) begin
            for (int i = 0; i < NC; i++) begin
                r_bcap[i] <= ((IdxW+1)'(i) < w_n) ?
                             r_bsh[TW'(w_n - (IdxW+1)'(i + 1))] : '0;
            end
            r_acap <= r_a_k;
        end
    end

    // chain of cells; each hands its fire control to the next
    assign w_ctl[0] = r_fire;
    for (genvar g = 0; g < NC; g++) begin : g_cell
        smm_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_ctl(w_ctl[g]), .i_a(r_acap), .i_b(r_bcap[g]),
            .o_ctl(w_ctl[g+1]), .o_acc(w_acc[g]));
    end

    // result channel: drain cell accumulators of this row
    assign m_out.valid           = (r_state == ST_DRAIN);
    assign m_out.product_element = w_acc[r_c];
    assign m_out.row_index       = r_row;
    assign m_out.column_index    = r_c;
    assign m_out.last_element    = ({1'b0, r_row} == w_n - 1'b1) &&
                                   ({1'b0, r_c} == w_n - 1'b1);

`ifndef SYNTH
    // no input accepted while results are pending
    a_no_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !s_in.ready) else $error("input during compute");
    // last flag only on the final column
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.last_element) |-> ({1'b0, m_out.column_index} == w_n - 1'b1))
        else $error("last flag misplaced");
    // drain holds its position while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> $stable(r_c) && $stable(r_row))
        else $error("position moved during stall");
    // control leaving the chain never clears without accumulating
    a_ctl_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[NC].clear |-> w_ctl[NC].mac) else $error("clear without accumulate");
`endif
endmodule
`default_nettype wire
